>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the pitch PID block.
// Include by bare file name; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define PFD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pfd check failed");

// Clocked assertion that also holds across reset.
`define PFD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pfd check failed");

`endif

>>> hw/rtl/pfd_pkg.sv
// Package for the pitch PID block: widths, register indexes, reset values,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned LIMIT_W   = 15;
  localparam int unsigned CFG_IDX_W = 3;

  // Datapath widths
  localparam int unsigned ERR_W     = 17;
  localparam int unsigned FILT_W    = 25;
  localparam int unsigned DIFF_W    = 26;
  localparam int unsigned INTEG_W   = 40;
  localparam int unsigned MUL_A_W   = 28;
  localparam int unsigned MUL_B_W   = 18;
  localparam int unsigned MUL_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned P_W       = 21;
  localparam int unsigned D_W       = 33;
  localparam int unsigned TI_W      = 35;
  localparam int unsigned SUM_W     = 36;
  localparam int unsigned DPROD_W   = 41;
  localparam int unsigned DSCALE_W  = 51;
  localparam int unsigned DNUM_W    = 31;
  localparam int unsigned IMAG_LO_W = 24;
  localparam int unsigned TI_LO_PW  = 40;
  localparam int unsigned TI_HI_PW  = 32;

  localparam int unsigned FILT_SHIFT = 16;
  localparam int unsigned P_SHIFT    = 12;
  localparam int unsigned DNUM_SHIFT = 20;

  // Iterative divider: two quotient bits per cycle
  localparam int unsigned DIV_W      = 56;
  localparam int unsigned DIVR_W     = 22;
  localparam int unsigned DIV_CYCLES = DIV_W / 2;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  // 4096 * 1000: Q4.12 gain scale times ms per second
  localparam logic [DIVR_W-1:0] TI_DIVISOR = 22'd4096000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PITCH_OFFSET      = 3'd0,
    CFG_GAIN_PROPORTIONAL = 3'd1,
    CFG_GAIN_INTEGRAL     = 3'd2,
    CFG_GAIN_DERIVATIVE   = 3'd3,
    CFG_FILTER_WEIGHT     = 3'd4,
    CFG_CORRECTION_LIMIT  = 3'd5
  } cfg_reg_t;

  localparam logic [DATA_W-1:0]  RST_PITCH_OFFSET      = 16'hAAD0;  // -21808
  localparam logic [DATA_W-1:0]  RST_GAIN_PROPORTIONAL = 16'd599;
  localparam logic [DATA_W-1:0]  RST_GAIN_INTEGRAL     = 16'd7209;
  localparam logic [DATA_W-1:0]  RST_GAIN_DERIVATIVE   = 16'd795;
  localparam logic [DATA_W-1:0]  RST_FILTER_WEIGHT     = 16'd6554;
  localparam logic [LIMIT_W-1:0] RST_CORRECTION_LIMIT  = 15'd10240;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_INTEG,
    ST_PROP,
    ST_DMUL,
    ST_DSCALE,
    ST_DSTART,
    ST_TISUM,
    ST_DWAIT,
    ST_TIWAIT,
    ST_SUM,
    ST_COMMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FILT,
    OP_INTEG,
    OP_PROP,
    OP_DMUL,
    OP_DSCALE,
    OP_D_START,
    OP_TI_SUM,
    OP_D_DONE,
    OP_TI_DONE,
    OP_SUM,
    OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_start;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/pfd_in_if.sv
// Sample channel: valid/ready handshake carrying pitch and tick time.
// Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pfd_in_if;
  import pfd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pitch_sample;
  logic [DATA_W-1:0]        elapsed_ms;

  modport source (output valid, output pitch_sample, output elapsed_ms, input ready);
  modport sink   (input valid, input pitch_sample, input elapsed_ms, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pfd_out_if.sv
// Result channel: valid/ready handshake carrying the clamped correction.
// Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pfd_out_if;
  import pfd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] correction;
  logic                     clamped;

  modport source (output valid, output correction, output clamped, input ready);
  modport sink   (input valid, input correction, input clamped, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pfd_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pfd_pkg::DIV_W-1:0]    dividend,
  input  logic [pfd_pkg::DIVR_W-1:0]   divisor,
  output logic                         busy,
  output logic [pfd_pkg::DIV_W-1:0]    quotient
);
  import pfd_pkg::*;

  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     quo_mid;
  logic [DIV_W-1:0]     quo_next;
  logic [DIVR_W-1:0]    rem;
  logic [DIVR_W-1:0]    rem_mid;
  logic [DIVR_W-1:0]    rem_next;
  logic [DIVR_W-1:0]    dsr;
  logic [DIV_CNT_W-1:0] count;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [DIVR_W+DIV_W-1:0] div_step(
    input logic [DIVR_W-1:0] r,
    input logic [DIV_W-1:0]  q,
    input logic [DIVR_W-1:0] d
  );
    logic [DIVR_W:0] trial;
    logic [DIVR_W:0] rest;
    trial = {r, q[DIV_W-1]};
    rest  = trial - {1'b0, d};
    if (!rest[DIVR_W]) begin
      return {rest[DIVR_W-1:0], q[DIV_W-2:0], 1'b1};
    end
    return {trial[DIVR_W-1:0], q[DIV_W-2:0], 1'b0};
  endfunction

  always_comb begin
    {rem_mid, quo_mid}   = div_step(rem, quo, dsr);
    {rem_next, quo_next} = div_step(rem_mid, quo_mid, dsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> hw/rtl/pfd_ctrl.sv
// Sequencer for one control tick: steps the datapath through its
// multiply, divide and commit phases. Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pfd_pkg::status_t status,
  output pfd_pkg::cmd_t    cmd
);
  import pfd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_FILT;
      ST_FILT:   state_next = ST_INTEG;
      ST_INTEG:  state_next = ST_PROP;
      ST_PROP:   state_next = ST_DMUL;
      ST_DMUL:   state_next = ST_DSCALE;
      ST_DSCALE: state_next = ST_DSTART;
      ST_DSTART: state_next = ST_TISUM;
      ST_TISUM:  state_next = ST_DWAIT;
      ST_DWAIT:  if (!status.div_busy) state_next = ST_TIWAIT;
      ST_TIWAIT: if (!status.div_busy) state_next = ST_SUM;
      ST_SUM:    state_next = ST_COMMIT;
      ST_COMMIT: if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_FILT:   cmd.op = OP_FILT;
      ST_INTEG:  cmd.op = OP_INTEG;
      ST_PROP:   cmd.op = OP_PROP;
      ST_DMUL:   cmd.op = OP_DMUL;
      ST_DSCALE: cmd.op = OP_DSCALE;
      ST_DSTART: begin
        cmd.op        = OP_D_START;
        cmd.div_start = 1'b1;
      end
      ST_TISUM:  cmd.op = OP_TI_SUM;
      ST_DWAIT: begin
        // take the derivative quotient and launch the integral divide
        if (!status.div_busy) begin
          cmd.op        = OP_D_DONE;
          cmd.div_start = 1'b1;
        end
      end
      ST_TIWAIT: if (!status.div_busy) cmd.op = OP_TI_DONE;
      ST_SUM:    cmd.op = OP_SUM;
      ST_COMMIT: if (status.out_free) cmd.op = OP_COMMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/pfd_dp.sv
// Datapath: configuration registers, filter and integral state, shared
// multiplier, divider and the output register. Depends on pfd_pkg, pfd_div, pfd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module pfd_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfd_pkg::DATA_W-1:0]       cfg_data,
  input  logic signed [pfd_pkg::DATA_W-1:0] pitch_sample,
  input  logic [pfd_pkg::DATA_W-1:0]       elapsed_ms,
  input  pfd_pkg::cmd_t                    cmd,
  output pfd_pkg::status_t                 status,
  pfd_out_if.source                        result
);
  import pfd_pkg::*;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Configuration
  logic signed [DATA_W-1:0] pitch_offset;
  logic [DATA_W-1:0]        gain_p;
  logic [DATA_W-1:0]        gain_i;
  logic [DATA_W-1:0]        gain_d;
  logic [DATA_W-1:0]        filter_weight;
  logic [LIMIT_W-1:0]       corr_limit;

  // Controller state across ticks
  logic signed [FILT_W-1:0]  filt;
  logic signed [INTEG_W-1:0] integ;

  // Per-item working registers
  logic signed [ERR_W-1:0]   err;
  logic [DATA_W-1:0]         ms;
  logic signed [MUL_W-1:0]   mul_p;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-2:0]         dmag;
  logic                      dneg;
  logic signed [INTEG_W-1:0] i_new;
  logic [INTEG_W-1:0]        imag;
  logic                      ineg;
  logic signed [P_W-1:0]     p_term;
  logic [DNUM_W-1:0]         d_num;
  logic [DIV_W-1:0]          ti_acc;
  logic signed [D_W-1:0]     d_term;
  logic signed [TI_W-1:0]    ti_term;
  logic signed [SUM_W-1:0]   sum;

  // Output register
  logic                      out_valid;
  logic signed [DATA_W-1:0]  correction;
  logic                      clamped;

  // Combinational
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_W-1:0]   mul_prod;
  logic                      mul_en;
  logic signed [DIFF_W-1:0]  x_filt;
  logic signed [MUL_W-1:0]   filt_rnd;
  logic signed [INTEG_W:0]   i_sum;
  logic signed [INTEG_W-1:0] i_sat;
  logic signed [DIFF_W-1:0]  diff_neg;
  logic [INTEG_W-1:0]        i_neg;
  logic signed [MUL_W-1:0]   p_rnd;
  logic [DPROD_W-1:0]        d_prod;
  logic [DSCALE_W-1:0]       d_scaled;
  logic [DIV_W-1:0]          div_dividend;
  logic [DIVR_W-1:0]         div_divisor;
  logic                      div_busy;
  logic [DIV_W-1:0]          div_q;
  logic signed [D_W-1:0]     d_pos;
  logic signed [TI_W-1:0]    ti_pos;
  logic signed [SUM_W-1:0]   lim_pos;
  logic signed [SUM_W-1:0]   lim_neg;
  logic                      over;
  logic                      under;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_offset  <= RST_PITCH_OFFSET;
      gain_p        <= RST_GAIN_PROPORTIONAL;
      gain_i        <= RST_GAIN_INTEGRAL;
      gain_d        <= RST_GAIN_DERIVATIVE;
      filter_weight <= RST_FILTER_WEIGHT;
      corr_limit    <= RST_CORRECTION_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PITCH_OFFSET:      pitch_offset  <= cfg_data;
        CFG_GAIN_PROPORTIONAL: gain_p        <= cfg_data;
        CFG_GAIN_INTEGRAL:     gain_i        <= cfg_data;
        CFG_GAIN_DERIVATIVE:   gain_d        <= cfg_data;
        CFG_FILTER_WEIGHT:     filter_weight <= cfg_data;
        CFG_CORRECTION_LIMIT:  corr_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  assign x_filt = (DIFF_W'(err) <<< 8) - DIFF_W'(filt);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_FILT: begin
        mul_a = MUL_A_W'(x_filt);
        mul_b = MUL_B_W'(filter_weight);
      end
      OP_INTEG: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(ms);
      end
      OP_PROP: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(gain_p);
      end
      OP_DMUL: begin
        mul_a = MUL_A_W'(dmag);
        mul_b = MUL_B_W'(gain_d);
      end
      OP_DSCALE: begin
        mul_a = MUL_A_W'(imag[IMAG_LO_W-1:0]);
        mul_b = MUL_B_W'(gain_i);
      end
      OP_D_START: begin
        mul_a = MUL_A_W'(imag[INTEG_W-1:IMAG_LO_W]);
        mul_b = MUL_B_W'(gain_i);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_prod = mul_a * mul_b;

  // Filter step: round half up of weight * (256e - f) / 2^16
  assign filt_rnd = mul_p + MUL_W'(32768);

  // Integral with saturation at the 40-bit range
  assign i_sum = (INTEG_W + 1)'(integ) + (INTEG_W + 1)'(mul_p);

  always_comb begin
    if (i_sum[INTEG_W] != i_sum[INTEG_W-1]) begin
      i_sat = i_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      i_sat = i_sum[INTEG_W-1:0];
    end
  end

  assign diff_neg = -diff;
  assign i_neg    = -i_new;

  // Proportional term rounds toward zero
  assign p_rnd = mul_p + (mul_p[MUL_W-1] ? MUL_W'((1 << P_SHIFT) - 1) : '0);

  // Scale Kd * |diff| by 1000 as 1024 - 16 - 8
  assign d_prod   = mul_p[DPROD_W-1:0];
  assign d_scaled = (DSCALE_W'(d_prod) << 10) - (DSCALE_W'(d_prod) << 4)
                  - (DSCALE_W'(d_prod) << 3);

  assign div_dividend = (cmd.op == OP_D_START) ? DIV_W'(d_num) : ti_acc;
  assign div_divisor  = (cmd.op == OP_D_START) ? DIVR_W'(ms) : TI_DIVISOR;

  pfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign d_pos  = {1'b0, div_q[D_W-2:0]};
  assign ti_pos = {1'b0, div_q[TI_W-2:0]};

  assign lim_pos = SUM_W'(corr_limit);
  assign lim_neg = -lim_pos;
  assign over    = sum > lim_pos;
  assign under   = sum < lim_neg;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_p <= mul_prod;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        err <= ERR_W'(pitch_offset) - ERR_W'(pitch_sample);
        ms  <= (elapsed_ms == '0) ? DATA_W'(1) : elapsed_ms;
      end
      OP_INTEG: diff <= filt_rnd[FILT_SHIFT +: DIFF_W];
      OP_PROP: begin
        i_new <= i_sat;
        dneg  <= diff[DIFF_W-1];
        dmag  <= diff[DIFF_W-1] ? diff_neg[DIFF_W-2:0] : diff[DIFF_W-2:0];
      end
      OP_DMUL: begin
        p_term <= p_rnd[P_SHIFT +: P_W];
        ineg   <= i_new[INTEG_W-1];
        imag   <= i_new[INTEG_W-1] ? i_neg : i_new;
      end
      OP_DSCALE:  d_num  <= d_scaled[DNUM_SHIFT +: DNUM_W];
      OP_D_START: ti_acc <= DIV_W'(mul_p[TI_LO_PW-1:0]);
      OP_TI_SUM:  ti_acc <= ti_acc + (DIV_W'(mul_p[TI_HI_PW-1:0]) << IMAG_LO_W);
      OP_D_DONE:  d_term <= dneg ? -d_pos : d_pos;
      OP_TI_DONE: ti_term <= ineg ? -ti_pos : ti_pos;
      OP_SUM:     sum <= SUM_W'(p_term) + SUM_W'(ti_term) + SUM_W'(d_term);
      default: ;
    endcase
  end

  // Tick state: filter always advances, integral holds when the clamp acts
  always_ff @(posedge clk) begin
    if (rst) begin
      filt  <= '0;
      integ <= '0;
    end else if (cmd.op == OP_COMMIT) begin
      filt <= filt + FILT_W'(diff);
      if (!(over || under)) begin
        integ <= i_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_COMMIT) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COMMIT) begin
      clamped <= over || under;
      if (over) begin
        correction <= lim_pos[DATA_W-1:0];
      end else if (under) begin
        correction <= lim_neg[DATA_W-1:0];
      end else begin
        correction <= sum[DATA_W-1:0];
      end
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || result.ready;

  assign result.valid      = out_valid;
  assign result.correction = correction;
  assign result.clamped    = clamped;

endmodule

`default_nettype wire

>>> hw/rtl/pid_filtered_derivative_antiwindup.sv
//  channel   dir  handshake      payload
//  sample    in   valid/ready    pitch_sample[15:0] s, elapsed_ms[15:0] u
//  result    out  valid/ready    correction[15:0] s, clamped
//  cfg       in   cfg_we         cfg_index[2:0], cfg_data[15:0]
//
// One item at a time: each item makes two passes through the radix-4 divider
// (derivative, then integral term) before its result commits.
// A new item is taken as soon as the previous one commits to the output
// register, even while that result still waits on result.ready.
// A stalled result holds the commit step; rst is synchronous, active high.
// Depends on pfd_pkg, pfd_in_if, pfd_out_if, pfd_ctrl, pfd_dp.
`timescale 1ns / 1ps
`default_nettype none

module pid_filtered_derivative_antiwindup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfd_pkg::DATA_W-1:0]    cfg_data,
  pfd_in_if.sink                        sample,
  pfd_out_if.source                     result
);
  import pfd_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  pfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pitch_sample (sample.pitch_sample),
    .elapsed_ms   (sample.elapsed_ms),
    .cmd          (cmd),
    .status       (status),
    .result       (result)
  );

  assign sample.ready = in_ready;

endmodule

`default_nettype wire

>>> hw/rtl/pfd_checker.sv
// Port-level checks for the pitch PID block, bound to the top level.
// Depends on assert_macros.svh and the top level's channels.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] correction,
  input logic        clamped
);

  // after reset: no result pending, ready for an item
  `PFD_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!out_valid && in_ready))

  // an accepted item occupies the block
  `PFD_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)

  // a stalled result holds
  `PFD_ASSERT(a_result_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(correction) && $stable(clamped)))

endmodule

bind pid_filtered_derivative_antiwindup pfd_checker u_pfd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample.valid),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .correction (result.correction),
  .clamped    (result.clamped)
);

`default_nettype wire
